// ===== rtl/delta_zigzag_varint_encoder_top_defines.svh =====
// assertion macros for the delta zigzag varint encoder
`ifndef DELTA_ZIGZAG_VARINT_ENCODER_TOP_DEFINES_SVH
`define DELTA_ZIGZAG_VARINT_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define DZV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dzv same-cycle check failed");

// next-cycle implication, checked on every clock outside reset
`define DZV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dzv next-cycle check failed");

`endif

// ===== rtl/dzv_pkg.sv =====
// shared constants and helpers for the delta zigzag varint encoder
package dzv_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned MAX_BYTES  = 5;
  localparam int unsigned PACK_W     = MAX_BYTES * BYTE_W;
  localparam int unsigned PCNT_W     = $clog2(MAX_BYTES + 1);
  localparam int unsigned SIGN_BIT   = 31;

  localparam logic [VALUE_W-1:0] ONE_BYTE_LIMIT = 32'd128;
  localparam logic [VALUE_W-1:0] TWO_BYTE_LIMIT = 32'd16384;
  localparam logic [BYTE_W-1:0]  CONT_BIT       = 8'h80;
  localparam logic [6:0]         LOW7_MASK      = 7'h7F;
  localparam logic [BYTE_W-1:0]  ESCAPE_BYTE    = 8'hFF;
  localparam logic [COUNT_W-1:0] CAP_RESET      = 16'hFFFF;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [PACK_W-1:0]  pack_t;
  typedef logic [PCNT_W-1:0]  pcnt_t;

  // (d << 1) ^ (all ones when d is negative)
  function automatic value_t zigzag(input value_t d);
    value_t shifted;
    shifted = {d[SIGN_BIT-1:0], 1'b0};
    return shifted ^ {VALUE_W{d[SIGN_BIT]}};
  endfunction

endpackage

// ===== rtl/dzv_if.sv =====
// handshake channels of the delta zigzag varint encoder

interface dzv_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   sample_value;
  logic                 first_of_array;
  modport source (output valid, output sample_value, output first_of_array, input ready);
  modport sink   (input valid, input sample_value, input first_of_array, output ready);
endinterface

interface dzv_out_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_byte;
  logic                 last_byte;
  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

interface dzv_cfg_if;
  logic                 valid;
  logic                 ready;
  logic [15:0]          wdata;
  modport source (output valid, output wdata, input ready);
  modport sink   (input valid, input wdata, output ready);
endinterface

// ===== rtl/delta_zigzag_varint_encoder_top.sv =====
// pipeline: an accepted word waits in the input register and is coded and loaded into the
// output shift register once that register is free; its bytes go out on the out channel from there
// throughput: one byte per cycle while the receiver is ready, from a five-byte output shift
// register; an item emits zero to five bytes, and the next word loads as its last byte leaves
// reset: previous value and byte count clear, capacity returns to 65535, channels empty
`include "delta_zigzag_varint_encoder_top_defines.svh"

module delta_zigzag_varint_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  dzv_in_if.sink     in_ch,
  dzv_out_if.source  out_ch,
  dzv_cfg_if.sink    cfg_ch
);

  logic              in_valid_r;
  dzv_pkg::value_t   in_value_r;
  logic              in_first_r;
  dzv_pkg::value_t   prev_r;
  dzv_pkg::count_t   bw_r;
  dzv_pkg::count_t   cap_r;
  dzv_pkg::pack_t    buf_r;
  dzv_pkg::pcnt_t    buf_cnt_r;

  logic              buf_free;
  logic              load;
  logic              out_fire;
  dzv_pkg::value_t   delta;
  dzv_pkg::value_t   zz;
  dzv_pkg::byte_t    lo_byte;
  dzv_pkg::byte_t    hi_byte;
  logic [16:0]       bw_x;
  logic [16:0]       cap_x;
  logic [16:0]       bw1;
  logic              w1;
  logic              w2;
  dzv_pkg::pack_t    pack_nxt;
  dzv_pkg::pcnt_t    pack_cnt_nxt;
  logic [16:0]       bw_nxt;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign buf_free = (buf_cnt_r == '0) || ((buf_cnt_r == dzv_pkg::pcnt_t'(1)) && out_ch.ready);
  assign load     = in_valid_r && buf_free;

  assign in_ch.ready      = !in_valid_r || load;
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = (buf_cnt_r != '0);
  assign out_ch.out_byte  = buf_r[dzv_pkg::BYTE_W-1:0];
  assign out_ch.last_byte = (buf_cnt_r == dzv_pkg::pcnt_t'(1));

  assign delta   = in_value_r - prev_r;
  assign zz      = dzv_pkg::zigzag(delta);
  assign lo_byte = dzv_pkg::CONT_BIT | {1'b0, zz[6:0] & dzv_pkg::LOW7_MASK};
  assign hi_byte = {1'b0, zz[13:7]};
  assign bw_x    = {1'b0, bw_r};
  assign cap_x   = {1'b0, cap_r};

  // each write is kept or dropped on its own against the running count
  always_comb begin
    pack_nxt     = '0;
    pack_cnt_nxt = '0;
    bw_nxt       = bw_x;
    w1           = 1'b0;
    w2           = 1'b0;
    bw1          = bw_x;
    if (in_first_r) begin
      w1     = (17'd4 <= cap_x);
      bw_nxt = w1 ? 17'd4 : 17'd0;
      bw1    = bw_nxt;
      if (w1) begin
        pack_nxt     = {8'h00, in_value_r};
        pack_cnt_nxt = dzv_pkg::pcnt_t'(4);
      end
    end else if (zz < dzv_pkg::ONE_BYTE_LIMIT) begin
      w1     = (bw_x + 17'd1 <= cap_x);
      bw1    = w1 ? bw_x + 17'd1 : bw_x;
      bw_nxt = bw1;
      if (w1) begin
        pack_nxt     = {32'h0, zz[7:0]};
        pack_cnt_nxt = dzv_pkg::pcnt_t'(1);
      end
    end else if (zz < dzv_pkg::TWO_BYTE_LIMIT) begin
      w1     = (bw_x + 17'd1 <= cap_x);
      bw1    = w1 ? bw_x + 17'd1 : bw_x;
      w2     = (bw1 + 17'd1 <= cap_x);
      bw_nxt = w2 ? bw1 + 17'd1 : bw1;
      case ({w1, w2})
        2'b11: begin
          pack_nxt     = {24'h0, hi_byte, lo_byte};
          pack_cnt_nxt = dzv_pkg::pcnt_t'(2);
        end
        2'b10: begin
          pack_nxt     = {32'h0, lo_byte};
          pack_cnt_nxt = dzv_pkg::pcnt_t'(1);
        end
        2'b01: begin
          pack_nxt     = {32'h0, hi_byte};
          pack_cnt_nxt = dzv_pkg::pcnt_t'(1);
        end
        default: begin
          pack_nxt     = '0;
          pack_cnt_nxt = '0;
        end
      endcase
    end else begin
      w1     = (bw_x + 17'd1 <= cap_x);
      bw1    = w1 ? bw_x + 17'd1 : bw_x;
      w2     = (bw1 + 17'd4 <= cap_x);
      bw_nxt = w2 ? bw1 + 17'd4 : bw1;
      case ({w1, w2})
        2'b11: begin
          pack_nxt     = {zz, dzv_pkg::ESCAPE_BYTE};
          pack_cnt_nxt = dzv_pkg::pcnt_t'(5);
        end
        2'b10: begin
          pack_nxt     = {32'h0, dzv_pkg::ESCAPE_BYTE};
          pack_cnt_nxt = dzv_pkg::pcnt_t'(1);
        end
        2'b01: begin
          pack_nxt     = {8'h00, zz};
          pack_cnt_nxt = dzv_pkg::pcnt_t'(4);
        end
        default: begin
          pack_nxt     = '0;
          pack_cnt_nxt = '0;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_value_r <= dzv_pkg::value_t'(in_ch.sample_value);
      in_first_r <= in_ch.first_of_array;
    end
  end

  // coder state and capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      bw_r   <= '0;
      cap_r  <= dzv_pkg::CAP_RESET;
    end else begin
      if (load) begin
        prev_r <= in_value_r;
        bw_r   <= bw_nxt[dzv_pkg::COUNT_W-1:0];
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        cap_r <= cfg_ch.wdata;
      end
    end
  end

  // output shift register, low byte goes first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
    end else if (load) begin
      buf_cnt_r <= pack_cnt_nxt;
    end else if (out_fire) begin
      buf_cnt_r <= buf_cnt_r - dzv_pkg::pcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= pack_nxt;
    end else if (out_fire) begin
      buf_r <= buf_r >> dzv_pkg::BYTE_W;
    end
  end

  `DZV_ASSERT_NOW(a_buf_cnt_range, 1'b1, buf_cnt_r <= dzv_pkg::pcnt_t'(dzv_pkg::MAX_BYTES))
  `DZV_ASSERT_NEXT(a_first_resets_count, load && in_first_r, bw_r <= 16'd4)
  `DZV_ASSERT_NEXT(a_prev_follows_item, load, prev_r == $past(in_value_r))
  `DZV_ASSERT_NEXT(a_shift_counts_down, out_fire && (buf_cnt_r > dzv_pkg::pcnt_t'(1)),
                   buf_cnt_r == $past(buf_cnt_r) - dzv_pkg::pcnt_t'(1))

endmodule

// ===== tb/delta_zigzag_varint_encoder_top_tb.sv =====
// self-checking testbench for the delta zigzag varint encoder, directed and random words
`timescale 1ns / 100ps

module delta_zigzag_varint_encoder_top_tb;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned PHASE_WORDS = 28;
  localparam int unsigned PRESS_WORDS = 50;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned PRESS_PHASE = 3;

  typedef struct packed {
    logic            first;
    dzv_pkg::value_t value;
  } word_t;

  typedef struct packed {
    dzv_pkg::byte_t val;
    logic           last;
  } coded_byte_t;

  logic clk;
  logic rst_n;

  dzv_in_if  in_if();
  dzv_out_if out_if();
  dzv_cfg_if cfg_if();

  delta_zigzag_varint_encoder_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  word_t       pending_words[$];
  coded_byte_t expected_bytes[$];

  // encoder state as predicted
  dzv_pkg::value_t last_value;
  int unsigned     kept_bytes;
  dzv_pkg::count_t capacity;

  dzv_pkg::value_t gen_last;
  word_t       next_word;
  coded_byte_t want;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned hold_left;
  int unsigned quiet;
  bit          in_idle_on;
  bit          out_idle_on;
  bit          hold_armed;
  int unsigned errors;
  int unsigned words_in;
  int unsigned bytes_out;
  int unsigned silent_words;
  int unsigned cfg_writes;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len(bit enabled);
    int unsigned r;
    r = $urandom_range(99);
    if (!enabled || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic void predict_encoding(word_t w);
    dzv_pkg::value_t d;
    dzv_pkg::value_t z;
    dzv_pkg::value_t chunk [3];
    int unsigned     chunk_len [3];
    int unsigned     n_chunks;
    dzv_pkg::byte_t  coded [5];
    int unsigned     n_coded;
    n_coded = 0;
    if (w.first) begin
      kept_bytes = 0;
      chunk[0] = w.value;
      chunk_len[0] = 4;
      n_chunks = 1;
    end else begin
      d = w.value - last_value;
      z = {d[30:0], 1'b0} ^ {32{d[31]}};
      if (z < dzv_pkg::ONE_BYTE_LIMIT) begin
        chunk[0] = z;
        chunk_len[0] = 1;
        n_chunks = 1;
      end else if (z < dzv_pkg::TWO_BYTE_LIMIT) begin
        chunk[0] = {24'd0, dzv_pkg::CONT_BIT | {1'b0, z[6:0]}};
        chunk_len[0] = 1;
        chunk[1] = z >> 7;
        chunk_len[1] = 1;
        n_chunks = 2;
      end else begin
        chunk[0] = {24'd0, dzv_pkg::ESCAPE_BYTE};
        chunk_len[0] = 1;
        chunk[1] = z;
        chunk_len[1] = 4;
        n_chunks = 2;
      end
    end
    // each write goes out whole or is dropped whole
    for (int i = 0; i < n_chunks; i++) begin
      if (kept_bytes + chunk_len[i] <= capacity) begin
        for (int j = 0; j < chunk_len[i]; j++) begin
          coded[n_coded] = chunk[i][8*j +: 8];
          n_coded++;
        end
        kept_bytes += chunk_len[i];
      end
    end
    last_value = w.value;
    if (n_coded == 0) silent_words++;
    for (int k = 0; k < n_coded; k++)
      expected_bytes.push_back(coded_byte_t'{coded[k], k == n_coded - 1});
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch on %s at byte %0d: got 0x%0h, expected 0x%0h",
             field, bytes_out, got, exp_val);
    errors++;
  endtask

  function automatic void queue_word(logic first, dzv_pkg::value_t value);
    pending_words.push_back(word_t'{first, value});
    gen_last = value;
  endfunction

  task automatic add_random_word(int unsigned first_pct);
    int unsigned     r;
    int              boundary;
    dzv_pkg::value_t v;
    r = $urandom_range(99);
    if (r < 40) begin
      v = gen_last + $urandom_range(127) - 32'd64;
    end else if (r < 70) begin
      v = gen_last + $urandom_range(16383) - 32'd8192;
    end else if (r < 80) begin
      case ($urandom_range(7))
        0: boundary = 63;
        1: boundary = -64;
        2: boundary = 64;
        3: boundary = -65;
        4: boundary = 8191;
        5: boundary = -8192;
        6: boundary = 8192;
        default: boundary = -8193;
      endcase
      v = gen_last + dzv_pkg::value_t'(boundary);
    end else if (r < 92) begin
      v = $urandom;
    end else begin
      v = gen_last + $urandom;
    end
    queue_word($urandom_range(99) < first_pct, v);
  endtask

  // block is idle once nothing is queued, offered or owed
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_if.valid || expected_bytes.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(dzv_pkg::count_t cap_value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.wdata <= cap_value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    capacity = cap_value;
    cfg_writes++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.sample_value <= '0;
      in_if.first_of_array <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_encoding(word_t'{in_if.first_of_array,
                                 dzv_pkg::value_t'(in_if.sample_value)});
        words_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_if.valid <= 1'b1;
          in_if.sample_value <= next_word.value;
          in_if.first_of_array <= next_word.first;
          in_gap = gap_len(in_idle_on);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and ready control
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_gap = 0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        bytes_out++;
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected word", 32'(out_if.out_byte), 32'd0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_if.out_byte !== want.val)
            report_mismatch("out_byte", 32'(out_if.out_byte), 32'(want.val));
          if (out_if.last_byte !== want.last)
            report_mismatch("last_byte", 32'(out_if.last_byte), 32'(want.last));
        end
        out_gap = gap_len(out_idle_on);
      end
      if (hold_left == 0 && hold_armed) begin
        hold_left = LONG_HOLD;
        hold_armed = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet = 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("delta_zigzag_varint_encoder_top_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    dzv_pkg::count_t cap_value;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample_value = '0;
    in_if.first_of_array = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.wdata = '0;
    capacity = dzv_pkg::CAP_RESET;
    last_value = '0;
    kept_bytes = 0;
    gen_last = '0;
    hold_armed = 1'b0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    errors = 0;
    words_in = 0;
    bytes_out = 0;
    silent_words = 0;
    cfg_writes = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unmarked words straight after reset code against zero
    queue_word(1'b0, 32'd5);
    queue_word(1'b0, 32'hFFFF_FFFD);
    queue_word(1'b1, 32'h8000_0000);
    queue_word(1'b1, 32'h7FFF_FFFF);
    queue_word(1'b0, 32'h8000_0000);
    queue_word(1'b0, 32'h7FFF_FFFF);
    queue_word(1'b1, 32'h0000_0000);
    queue_word(1'b0, 32'h0000_0000);
    queue_word(1'b0, 32'd63);
    queue_word(1'b0, 32'hFFFF_FFFF);
    queue_word(1'b0, 32'd63);
    // two-byte form whose low bits collide with the escape byte
    queue_word(1'b0, 32'hFFFF_FFBF);
    queue_word(1'b0, 32'd8126);
    queue_word(1'b0, 32'hFFFF_FFBE);
    queue_word(1'b0, 32'd8126);
    queue_word(1'b1, 32'h0000_0000);
    queue_word(1'b0, 32'h8000_0000);
    queue_word(1'b0, 32'h7FFF_FFFF);
    queue_word(1'b0, 32'h0000_0000);
    queue_word(1'b1, 32'h5555_5555);
    queue_word(1'b0, 32'hAAAA_AAAA);
    queue_word(1'b1, 32'hFFFF_FFFF);
    queue_word(1'b0, 32'h0000_0001);
    queue_word(1'b0, 32'h4000_0001);
    wait_drained();

    // words are marked first only at random, so a lowered capacity can hit a running array
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:           cap_value = 16'd0;
        1:           cap_value = 16'd1;
        2:           cap_value = 16'd5;
        PRESS_PHASE: cap_value = dzv_pkg::CAP_RESET;
        4:           cap_value = 16'd2;
        5:           cap_value = dzv_pkg::count_t'($urandom_range(40, 3));
        6:           cap_value = 16'd4;
        7:           cap_value = dzv_pkg::count_t'($urandom_range(65535));
        8:           cap_value = 16'd6;
        default:     cap_value = dzv_pkg::CAP_RESET;
      endcase
      write_capacity(cap_value);
      @(negedge clk);
      in_idle_on = (p % 3 != 1) && (p != PRESS_PHASE);
      out_idle_on = (p % 3 != 1);
      if (p == PRESS_PHASE) begin
        hold_armed = 1'b1;
        for (int i = 0; i < PRESS_WORDS; i++) add_random_word(8);
      end else begin
        for (int i = 0; i < PHASE_WORDS; i++) add_random_word(cap_value < 64 ? 30 : 8);
      end
      wait_drained();
    end

    $display("run covered %0d words in and %0d bytes out, %0d words with every write dropped",
             words_in, bytes_out, silent_words);
    $display("%0d capacity settings from 0 to 65535, one long receiver stall", cfg_writes);
    if (errors == 0) begin
      $display("delta_zigzag_varint_encoder_top_tb OK");
    end else begin
      $display("delta_zigzag_varint_encoder_top_tb NOT OK");
    end
    $finish;
  end

endmodule
